@@ rtl/gba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap allocator package
// Shared types, codes and constants for the allocator modules.
// ----------------------------------------------------------------------------
package gba_pkg;

   localparam int GROUPS_DEFAULT = 8;
   localparam int BITS_PER_GROUP_DEFAULT = 8192;

   localparam int WORD_BITS = 64;
   localparam int WORD_SHIFT = 6;

   localparam int NUM_W = 17;
   localparam int UPG_W = 14;
   localparam int GC_W = 4;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [UPG_W-1:0] GROUP_FREE_RESET = 14'd8192;
   localparam logic [UPG_W-1:0] GROUP_FREE_MAX = 14'd16383;
   localparam logic [NUM_W-1:0] TOTAL_FREE_RESET = 17'd65536;
   localparam logic [NUM_W-1:0] TOTAL_FREE_MAX = 17'd131071;

   localparam logic [UPG_W-1:0] UPG_RESET = 14'd8192;
   localparam logic [NUM_W-1:0] TOTAL_RESET = 17'd65536;
   localparam logic [GC_W-1:0] GC_RESET = 4'd8;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   typedef enum logic [1:0] {
      REG_UNITS_PER_GROUP = 2'd0,
      REG_TOTAL_UNITS = 2'd1,
      REG_GROUP_COUNT = 2'd2,
      REG_NUMBERING_BASE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [UPG_W-1:0] units_per_group;
      logic [NUM_W-1:0] total_units;
      logic [GC_W-1:0]  group_count;
      logic             numbering_base;
   } cfg_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_AGRP,
      S_ARD,
      S_ACHK,
      S_FCHK,
      S_FDIV,
      S_FRD,
      S_FCHK2
   } state_type;

endpackage

@@ rtl/gba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/gba_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator configuration registers
// APB-style register file holding the geometry and numbering settings.
// ----------------------------------------------------------------------------
module gba_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gba_pkg::ADDR_W-1:0]  paddr,
   input  logic [gba_pkg::DATA_W-1:0]  pwdata,
   output logic [gba_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output gba_pkg::cfg_type            cfg
);
   import gba_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(paddr[3:2]);
   assign wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_UNITS_PER_GROUP: cfg_in.units_per_group = pwdata[UPG_W-1:0];
            REG_TOTAL_UNITS:     cfg_in.total_units = pwdata[NUM_W-1:0];
            REG_GROUP_COUNT:     cfg_in.group_count = pwdata[GC_W-1:0];
            REG_NUMBERING_BASE:  cfg_in.numbering_base = pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_UNITS_PER_GROUP: prdata = DATA_W'(cfg_ff.units_per_group);
         REG_TOTAL_UNITS:     prdata = DATA_W'(cfg_ff.total_units);
         REG_GROUP_COUNT:     prdata = DATA_W'(cfg_ff.group_count);
         REG_NUMBERING_BASE:  prdata = DATA_W'(cfg_ff.numbering_base);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.units_per_group <= UPG_RESET;
         cfg_ff.total_units <= TOTAL_RESET;
         cfg_ff.group_count <= GC_RESET;
         cfg_ff.numbering_base <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

@@ rtl/gba_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks groups and bitmap words, testing every bit of a read word in parallel.
// ----------------------------------------------------------------------------
module gba_core #(
   parameter int GROUPS = gba_pkg::GROUPS_DEFAULT,
   parameter int BITS_PER_GROUP = gba_pkg::BITS_PER_GROUP_DEFAULT,
   parameter int AW = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gba_pkg::cfg_type                 cfg,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [gba_pkg::NUM_W-1:0]        req_unit_number,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [gba_pkg::NUM_W-1:0]        rsp_granted_unit,
   output logic [gba_pkg::NUM_W-1:0]        rsp_free_total,
   output logic                             ram_we,
   output logic [AW-1:0]                    ram_waddr,
   output logic [gba_pkg::WORD_BITS-1:0]    ram_wdata,
   output logic                             ram_re,
   output logic [AW-1:0]                    ram_raddr,
   input  logic [gba_pkg::WORD_BITS-1:0]    ram_rdata
);
   import gba_pkg::*;

   localparam int DEPTH = (GROUPS * BITS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
   localparam int IDXW = $clog2(GROUPS * BITS_PER_GROUP + WORD_BITS) + 1;
   localparam int SW = IDXW + 2;
   localparam int GW = $clog2(GROUPS + 1);
   localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [GW-1:0] g_ff, g_in;
   logic [SW-1:0] idx0_ff, idx0_in;
   logic [SW-1:0] nstart_ff, nstart_in;
   logic signed [SW-1:0] bbase_ff, bbase_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [WORD_SHIFT-1:0] bit_ff, bit_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [UPG_W-1:0] fig_ff [GROUPS];
   logic [UPG_W-1:0] fig_in [GROUPS];
   logic [NUM_W-1:0] ftot_ff, ftot_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [NUM_W-1:0] rsp_ftot_ff, rsp_ftot_in;

   logic [SW-1:0] upg_w, eu, lim, fidx, nhit;
   logic signed [SW-1:0] eu_s, nb;
   logic [7:0] gc8, eg8;
   logic [GW-1:0] eg;
   logic signed [SW-1:0] bi_w [WORD_BITS];
   logic [SW-1:0] ni_w [WORD_BITS];
   logic [WORD_BITS-1:0] cand;
   logic found;
   logic [WORD_SHIFT-1:0] hit;
   logic [GIW-1:0] gi;

   assign upg_w = SW'(cfg.units_per_group);
   assign eu = (upg_w > SW'(BITS_PER_GROUP)) ? SW'(BITS_PER_GROUP) : upg_w;
   assign eu_s = signed'(eu);
   assign gc8 = 8'(cfg.group_count);
   assign eg8 = (gc8 > 8'(GROUPS)) ? 8'(GROUPS) : gc8;
   assign eg = GW'(eg8);
   assign lim = SW'(cfg.total_units) + SW'(cfg.numbering_base);
   assign gi = g_ff[GIW-1:0];
   assign fidx = idx0_ff + rem_ff;
   assign nb = bbase_ff + SW'(WORD_BITS);

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         bi_w[i] = bbase_ff + SW'(i);
         ni_w[i] = nstart_ff + $unsigned(bi_w[i]);
         cand[i] = !bi_w[i][SW-1] && (bi_w[i] < eu_s) && (ni_w[i] != '0)
                   && (ni_w[i] < lim) && !ram_rdata[i];
      end
   end

   always_comb begin
      hit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit = WORD_SHIFT'(i);
         end
      end
   end

   assign found = |cand;
   assign nhit = ni_w[hit];

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      g_in = g_ff;
      idx0_in = idx0_ff;
      nstart_in = nstart_ff;
      bbase_in = bbase_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      num_in = num_ff;
      fig_in = fig_ff;
      ftot_in = ftot_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_ftot_in = rsp_ftot_ff;
      ram_we = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = '0;
      ram_re = 1'b0;
      ram_raddr = addr_ff;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               g_in = '0;
               idx0_in = '0;
               nstart_in = SW'(cfg.numbering_base);
               num_in = req_unit_number;
               state_in = (req_op == OP_FREE) ? S_FCHK : S_AGRP;
            end
         end
         S_AGRP: begin
            if (g_ff >= eg) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_NO_FREE;
               rsp_granted_in = '0;
               rsp_ftot_in = ftot_ff;
               state_in = S_IDLE;
            end else if (fig_ff[gi] != '0 && eu != '0) begin
               addr_in = AW'(idx0_ff >> WORD_SHIFT);
               bbase_in = -signed'(SW'(idx0_ff[WORD_SHIFT-1:0]));
               state_in = S_ARD;
            end else begin
               g_in = g_ff + 1'b1;
               idx0_in = idx0_ff + SW'(BITS_PER_GROUP);
               nstart_in = nstart_ff + eu;
            end
         end
         S_ARD: begin
            ram_re = 1'b1;
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (found) begin
               ram_we = 1'b1;
               ram_wdata = ram_rdata | (WORD_BITS'(1) << hit);
               fig_in[gi] = fig_ff[gi] - 1'b1;
               ftot_in = (ftot_ff != '0) ? ftot_ff - 1'b1 : ftot_ff;
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_granted_in = NUM_W'(nhit);
               rsp_ftot_in = ftot_in;
               state_in = S_IDLE;
            end else if (nb >= eu_s) begin
               g_in = g_ff + 1'b1;
               idx0_in = idx0_ff + SW'(BITS_PER_GROUP);
               nstart_in = nstart_ff + eu;
               state_in = S_AGRP;
            end else begin
               bbase_in = nb;
               addr_in = addr_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         S_FCHK: begin
            if (eu == '0 || num_ff == '0 || SW'(num_ff) >= lim) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_INVALID;
               rsp_granted_in = '0;
               rsp_ftot_in = ftot_ff;
               state_in = S_IDLE;
            end else begin
               rem_in = SW'(num_ff) - SW'(cfg.numbering_base);
               state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            if (g_ff >= eg) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_INVALID;
               rsp_granted_in = '0;
               rsp_ftot_in = ftot_ff;
               state_in = S_IDLE;
            end else if (rem_ff < eu) begin
               addr_in = AW'(fidx >> WORD_SHIFT);
               bit_in = fidx[WORD_SHIFT-1:0];
               state_in = S_FRD;
            end else begin
               rem_in = rem_ff - eu;
               g_in = g_ff + 1'b1;
               idx0_in = idx0_ff + SW'(BITS_PER_GROUP);
            end
         end
         S_FRD: begin
            ram_re = 1'b1;
            state_in = S_FCHK2;
         end
         S_FCHK2: begin
            rsp_valid_in = 1'b1;
            rsp_granted_in = '0;
            state_in = S_IDLE;
            if (!ram_rdata[bit_ff]) begin
               rsp_status_in = STATUS_INVALID;
               rsp_ftot_in = ftot_ff;
            end else begin
               ram_we = 1'b1;
               ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_ff);
               if (fig_ff[gi] < GROUP_FREE_MAX) begin
                  fig_in[gi] = fig_ff[gi] + 1'b1;
               end
               ftot_in = (ftot_ff < TOTAL_FREE_MAX) ? ftot_ff + 1'b1 : ftot_ff;
               rsp_status_in = STATUS_DONE;
               rsp_ftot_in = ftot_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ftot_ff <= TOTAL_FREE_RESET;
         for (int i = 0; i < GROUPS; i++) begin
            fig_ff[i] <= GROUP_FREE_RESET;
         end
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         ftot_ff <= ftot_in;
         fig_ff <= fig_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff <= g_in;
      idx0_ff <= idx0_in;
      nstart_ff <= nstart_in;
      bbase_ff <= bbase_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      num_ff <= num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_ftot_ff <= rsp_ftot_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_unit = rsp_granted_ff;
   assign rsp_free_total = rsp_ftot_ff;
endmodule

@@ rtl/grouped_bitmap_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap allocator
// First-fit unit allocator over a grouped bitmap with free counters.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low: req_op selects
// allocate or free, req_unit_number names the unit to free. Exactly one
// result beat follows, shown for one cycle with rsp_valid high; the receiver
// cannot stall it. busy is low again in the cycle the result is shown.
// The bitmap sits in a RAM of 64-bit words and is walked by one sequencer.
// An allocate steps through the groups, passing over those with no free
// unit, and reads and checks the bitmap words of a group in turn until it
// finds a free unit or has tried every enabled group.
// A free checks the number, then finds the group index by repeated
// subtraction of the group size before it reads and updates the word; a
// number that fails the first range check is answered straight from that check.
// After reset the RAM is cleared one word a cycle with busy high, over
// GROUPS*BITS_PER_GROUP/64 words (1024 by default); the
// APB registers accept writes during that pass. Group counters reset to
// 8192 each and the total counter to 65536.
// ----------------------------------------------------------------------------
module grouped_bitmap_allocator_top #(
   parameter int GROUPS = gba_pkg::GROUPS_DEFAULT,
   parameter int BITS_PER_GROUP = gba_pkg::BITS_PER_GROUP_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [gba_pkg::NUM_W-1:0]   req_unit_number,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [gba_pkg::NUM_W-1:0]   rsp_granted_unit,
   output logic [gba_pkg::NUM_W-1:0]   rsp_free_total,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gba_pkg::ADDR_W-1:0]  paddr,
   input  logic [gba_pkg::DATA_W-1:0]  pwdata,
   output logic [gba_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import gba_pkg::*;

   localparam int DEPTH = (GROUPS * BITS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type cfg;
   logic ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   gba_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .cfg(cfg)
   );

   gba_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
   );

   gba_core #(.GROUPS(GROUPS), .BITS_PER_GROUP(BITS_PER_GROUP), .AW(AW)) u_core (
      .clock(clock), .reset(reset), .cfg(cfg), .start(start), .busy(busy),
      .req_op(req_op), .req_unit_number(req_unit_number),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_granted_unit(rsp_granted_unit), .rsp_free_total(rsp_free_total),
      .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
      .ram_re(ram_re), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
   );
endmodule

@@ rtl/gba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the request and result ports of the allocator over time.
// ----------------------------------------------------------------------------
module gba_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [1:0]                 rsp_status,
   input logic [gba_pkg::NUM_W-1:0]  rsp_granted_unit
);
   import gba_pkg::*;

   // An accepted request beat keeps the block busy until its result.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted request");

   // A result is shown only once the block has finished its work.
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Each request produces a single result beat.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A failed request grants nothing.
   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DONE) |-> (rsp_granted_unit == '0))
      else $error("unit granted on a failed request");
endmodule

bind grouped_bitmap_allocator_top gba_port_checker u_gba_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_granted_unit(rsp_granted_unit)
);

@@ sim/gba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap allocator checker
// Watches the request, result and register ports, keeps its own copy of the
// bitmap, the free counters and the settings, works out the result beat of
// every accepted request and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module gba_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_op,
   input  logic [gba_pkg::NUM_W-1:0]  req_unit_number,
   input  logic                       rsp_valid,
   input  logic [1:0]                 rsp_status,
   input  logic [gba_pkg::NUM_W-1:0]  rsp_granted_unit,
   input  logic [gba_pkg::NUM_W-1:0]  rsp_free_total,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [gba_pkg::ADDR_W-1:0] paddr,
   input  logic [gba_pkg::DATA_W-1:0] pwdata,
   output int                         failures,
   output int                         pending
);
   import gba_pkg::*;

   typedef struct packed {
      logic [1:0]       status;
      logic [NUM_W-1:0] granted;
      logic [NUM_W-1:0] free_total;
   } outcome_type;

   localparam int MAP_WORDS = GROUPS_DEFAULT * BITS_PER_GROUP_DEFAULT / 64;

   logic [63:0]      usage_map [MAP_WORDS];
   logic [UPG_W-1:0] group_free [GROUPS_DEFAULT];
   logic [NUM_W-1:0] total_free;
   cfg_type          cfg;
   outcome_type      outcomes [$];

   function automatic bit number_ok(int n);
      if (cfg.numbering_base)
         return n >= 1 && n <= int'(cfg.total_units);
      return n != 0 && n < int'(cfg.total_units);
   endfunction

   function automatic int units_used();
      return cfg.units_per_group > BITS_PER_GROUP_DEFAULT ? BITS_PER_GROUP_DEFAULT
                                                          : int'(cfg.units_per_group);
   endfunction

   function automatic int groups_used();
      return cfg.group_count > GROUPS_DEFAULT ? GROUPS_DEFAULT : int'(cfg.group_count);
   endfunction

   function automatic outcome_type allocate_unit();
      outcome_type o;
      int u;
      int gn;
      int b;
      int idx;
      int n;
      u = units_used();
      gn = groups_used();
      o = '0;
      o.status = STATUS_NO_FREE;
      for (int g = 0; g < gn; g++) begin
         if (group_free[g] == 0) continue;
         b = 0;
         while (b < u) begin
            idx = g * BITS_PER_GROUP_DEFAULT + b;
            n = g * u + b + int'(cfg.numbering_base);
            if (n >= int'(cfg.total_units) + int'(cfg.numbering_base)) begin
               o.free_total = total_free;
               return o;
            end
            if (idx % 64 == 0 && b + 64 <= u && usage_map[idx / 64] == '1) begin
               b += 64;
               continue;
            end
            if (!usage_map[idx / 64][idx % 64] && number_ok(n)) begin
               usage_map[idx / 64][idx % 64] = 1'b1;
               group_free[g] = group_free[g] - 1'b1;
               if (total_free != 0) total_free = total_free - 1'b1;
               o.status = STATUS_DONE;
               o.granted = NUM_W'(n);
               o.free_total = total_free;
               return o;
            end
            b++;
         end
      end
      o.free_total = total_free;
      return o;
   endfunction

   function automatic outcome_type free_unit(int n);
      outcome_type o;
      int u;
      int g;
      int idx;
      u = units_used();
      o = '0;
      o.status = STATUS_INVALID;
      o.free_total = total_free;
      if (u == 0 || !number_ok(n)) return o;
      g = (n - int'(cfg.numbering_base)) / u;
      idx = g * BITS_PER_GROUP_DEFAULT + (n - int'(cfg.numbering_base)) % u;
      if (g >= groups_used()) return o;
      if (!usage_map[idx / 64][idx % 64]) return o;
      usage_map[idx / 64][idx % 64] = 1'b0;
      if (group_free[g] < GROUP_FREE_MAX) group_free[g] = group_free[g] + 1'b1;
      if (total_free < TOTAL_FREE_MAX) total_free = total_free + 1'b1;
      o.status = STATUS_DONE;
      o.free_total = total_free;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (usage_map[i]) usage_map[i] = '0;
         foreach (group_free[i]) group_free[i] = GROUP_FREE_RESET;
         total_free = TOTAL_FREE_RESET;
         cfg.units_per_group = UPG_RESET;
         cfg.total_units = TOTAL_RESET;
         cfg.group_count = GC_RESET;
         cfg.numbering_base = 1'b0;
         outcomes.delete();
         failures = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_UNITS_PER_GROUP: cfg.units_per_group = pwdata[UPG_W-1:0];
               REG_TOTAL_UNITS:     cfg.total_units = pwdata[NUM_W-1:0];
               REG_GROUP_COUNT:     cfg.group_count = pwdata[GC_W-1:0];
               REG_NUMBERING_BASE:  cfg.numbering_base = pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (outcomes.size() == 0) begin
               $error("result beat with no request waiting");
               failures++;
            end else begin
               want = outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_granted_unit !== want.granted) begin
                  $error("granted_unit: expected %0d, got %0d", want.granted,
                         rsp_granted_unit);
                  failures++;
               end
               if (rsp_free_total !== want.free_total) begin
                  $error("free_total: expected %0d, got %0d", want.free_total,
                         rsp_free_total);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            if (req_op == OP_ALLOC) outcomes.push_back(allocate_unit());
            else outcomes.push_back(free_unit(int'(req_unit_number)));
         end
      end
      pending = outcomes.size();
   end

endmodule

@@ sim/grouped_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap allocator testbench
// Drives directed and random allocate and free requests under several
// register settings and sender idling patterns; the checker predicts and
// compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module grouped_bitmap_allocator_top_tb;
   import gba_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_op = OP_ALLOC;
   logic [NUM_W-1:0]  req_unit_number = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [NUM_W-1:0]  rsp_granted_unit;
   logic [NUM_W-1:0]  rsp_free_total;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                failures;
   int                pending;
   int                sent = 0;
   int                received = 0;
   int                quiet_cycles = 0;
   int                idle_pct = 0;
   int                total_now = 65536;

   grouped_bitmap_allocator_top dut (
      .clock, .reset, .start, .busy, .req_op, .req_unit_number,
      .rsp_valid, .rsp_status, .rsp_granted_unit, .rsp_free_total,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   gba_checker u_checker (
      .clock, .reset, .start, .busy, .req_op, .req_unit_number,
      .rsp_valid, .rsp_status, .rsp_granted_unit, .rsp_free_total,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .failures, .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_valid) received <= received + 1;
      if ((start && !busy) || rsp_valid || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic op, logic [NUM_W-1:0] unit);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_unit_number <= unit;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type index, int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == REG_TOTAL_UNITS) total_now = value;
   endtask

   task automatic configure(int upg, int total, int groups, int base);
      drain();
      write_reg(REG_UNITS_PER_GROUP, upg);
      write_reg(REG_TOTAL_UNITS, total);
      write_reg(REG_GROUP_COUNT, groups);
      write_reg(REG_NUMBERING_BASE, base);
   endtask

   task automatic random_request();
      logic [NUM_W-1:0] unit;
      if ($urandom_range(9) == 0) unit = NUM_W'($urandom);
      else unit = NUM_W'($urandom_range(0, total_now + 2));
      send_request($urandom_range(99) < 55 ? OP_ALLOC : OP_FREE, unit);
   endtask

   initial begin
      int modes[4];
      int upg;
      int groups;
      modes = '{0, 45, 0, 14};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      repeat (3) send_request(OP_ALLOC, '1);
      send_request(OP_FREE, 17'd2);
      send_request(OP_FREE, 17'd2);
      send_request(OP_FREE, 17'd0);
      send_request(OP_FREE, 17'd65535);
      send_request(OP_FREE, 17'd65536);
      send_request(OP_FREE, 17'h1FFFF);
      send_request(OP_ALLOC, 17'd0);
      configure(8192, 65536, 8, 1);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 17'd1);
      configure(16383, 131071, 15, 0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 17'd8193);
      configure(0, 100, 8, 0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 17'd5);
      configure(4, 100, 0, 0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 17'd5);
      configure(3, 7, 3, 0);
      repeat (8) send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 17'd4);

      for (int phase = 0; phase < 8; phase++) begin
         idle_pct = modes[phase % 4];
         if (phase == 3) begin
            configure(8192, 65536, 8, phase % 2);
         end else if (phase == 6) begin
            configure(16383, 131071, 15, 1);
         end else begin
            upg = $urandom_range(1, 12);
            groups = $urandom_range(1, 8);
            configure(upg, $urandom_range(1, upg * groups + 2), groups,
                      $urandom_range(0, 1));
         end
         repeat (250) random_request();
      end

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
